// ===== src/bcd_time_of_day_clock_with_ram_core_macros.svh =====
// Assertion macros used by the checker of the BCD time-of-day clock.
// No dependencies; each macro expects clk_i, and BCDTOD_ASSERT also rst_ni, in the scope where it is used.
`ifndef BCD_TIME_OF_DAY_CLOCK_WITH_RAM_CORE_MACROS_SVH
`define BCD_TIME_OF_DAY_CLOCK_WITH_RAM_CORE_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define BCDTOD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked assertion that also holds while reset is asserted.
`define BCDTOD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== src/bcdtod_pkg.sv =====
// Shared types, constants and helper functions of the BCD time-of-day clock.
// No dependencies; used by the interfaces, the RAM, the top level and the checker.
package bcdtod_pkg;

  // Battery RAM size and the index width that follows from it.
  localparam int RamBytes = 31;
  localparam int RamAw    = (RamBytes > 1) ? $clog2(RamBytes) : 1;

  // Field widths of a request and a result.
  localparam int OpW   = 3;
  localparam int HourW = 5;
  localparam int MinW  = 6;
  localparam int SecW  = 6;
  localparam int AddrW = 6;
  localparam int DataW = 8;
  localparam int HourBcdW = 6;
  localparam int MinBcdW  = 7;
  localparam int SecBcdW  = 7;

  // Time limits.
  localparam logic [HourW-1:0] HourMax = 5'd23;
  localparam logic [MinW-1:0]  MinMax  = 6'd59;
  localparam logic [SecW-1:0]  SecMax  = 6'd59;

  // Operation codes.
  typedef enum logic [OpW-1:0] {
    OpTick     = 3'd0,
    OpSetTime  = 3'd1,
    OpReadTime = 3'd2,
    OpReadMem  = 3'd3,
    OpWriteMem = 3'd4
  } op_e;

  // Access to the battery RAM for one accepted request.
  typedef struct packed {
    logic             take;   // a request is accepted this cycle
    logic             rd;     // read memory
    logic             wr;     // write memory
    logic [AddrW-1:0] addr;
    logic [DataW-1:0] wdata;
  } ram_req_t;

  // Binary value of at most 63 to two packed BCD digits.
  function automatic logic [7:0] to_bcd(input logic [5:0] v);
    logic [2:0] tens;
    logic [5:0] units;
    if (v >= 6'd60) begin
      tens = 3'd6;
    end else if (v >= 6'd50) begin
      tens = 3'd5;
    end else if (v >= 6'd40) begin
      tens = 3'd4;
    end else if (v >= 6'd30) begin
      tens = 3'd3;
    end else if (v >= 6'd20) begin
      tens = 3'd2;
    end else if (v >= 6'd10) begin
      tens = 3'd1;
    end else begin
      tens = 3'd0;
    end
    units = v - 6'(6'(tens) * 6'd10);
    return {1'b0, tens, units[3:0]};
  endfunction

endpackage

// ===== src/bcdtod_if.sv =====
// Request and result channel interfaces of the BCD time-of-day clock.
// Depends on bcdtod_pkg for the field widths.

// Request channel: one operation per request.
interface bcdtod_op_if;
  import bcdtod_pkg::*;

  logic             valid;
  logic             ready;
  logic [OpW-1:0]   operation;
  logic [HourW-1:0] set_hour;
  logic [MinW-1:0]  set_minute;
  logic [SecW-1:0]  set_second;
  logic [AddrW-1:0] mem_address;
  logic [DataW-1:0] write_data;

  modport source (
    output valid, operation, set_hour, set_minute, set_second, mem_address, write_data,
    input  ready
  );
  modport sink (
    input  valid, operation, set_hour, set_minute, set_second, mem_address, write_data,
    output ready
  );
endinterface

// Result channel: the BCD time and a RAM byte.
interface bcdtod_res_if;
  import bcdtod_pkg::*;

  logic                valid;
  logic                ready;
  logic [HourBcdW-1:0] hour_bcd;
  logic [MinBcdW-1:0]  minute_bcd;
  logic [SecBcdW-1:0]  second_bcd;
  logic [DataW-1:0]    read_data;

  modport source (
    output valid, hour_bcd, minute_bcd, second_bcd, read_data,
    input  ready
  );
  modport sink (
    input  valid, hour_bcd, minute_bcd, second_bcd, read_data,
    output ready
  );
endinterface

// ===== src/bcdtod_ram.sv =====
// Battery RAM of the BCD time-of-day clock with registered read data.
// Depends on bcdtod_pkg; per-entry valid bits make every byte read as zero after reset.
module bcdtod_ram (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  bcdtod_pkg::ram_req_t      req_i,
  output logic [bcdtod_pkg::DataW-1:0] rdata_o
);
  import bcdtod_pkg::*;

  logic [DataW-1:0]    mem_q [RamBytes];
  logic [RamBytes-1:0] vld_q;
  logic [RamAw-1:0]    idx;
  logic                in_range;
  logic [DataW-1:0]    rdata_q;

  // Addresses at or beyond the RAM size are ignored.
  assign in_range = ({1'b0, req_i.addr} < (AddrW + 1)'(RamBytes));
  assign idx      = req_i.addr[RamAw-1:0];

  // Storage write.
  always_ff @(posedge clk_i) begin
    if (req_i.wr && in_range) begin
      mem_q[idx] <= req_i.wdata;
    end
  end

  // An entry becomes valid once written; reset returns all entries to zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (req_i.wr && in_range) begin
      vld_q[idx] <= 1'b1;
    end
  end

  // Read data follows each accepted request and holds until the next one.
  always_ff @(posedge clk_i) begin
    if (req_i.take) begin
      if (req_i.rd && in_range && vld_q[idx]) begin
        rdata_q <= mem_q[idx];
      end else begin
        rdata_q <= '0;
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/bcd_time_of_day_clock_with_ram_core.sv =====
// Top level of the BCD time-of-day clock with battery RAM.
// Depends on bcdtod_pkg, bcdtod_op_if, bcdtod_res_if and bcdtod_ram.
//
//   Channel   Dir   Carries
//   req_i     in    operation, set_hour, set_minute, set_second, mem_address, write_data
//   rsp_o     out   hour_bcd, minute_bcd, second_bcd, read_data
//
// The result register is loaded at the accepting edge and the result is valid in the
// following cycle; one request per cycle is sustained while results are taken.
// The result is formed combinationally from the next time and held in one output register.
// Reset (rst_ni, asynchronous) clears the time to 00:00:00 and marks every RAM byte as zero;
// no clearing pass is needed. A stalled result holds while a new request is still accepted
// in the cycle the pending result is taken.
module bcd_time_of_day_clock_with_ram_core (
  input logic         clk_i,
  input logic         rst_ni,
  bcdtod_op_if.sink   req_i,
  bcdtod_res_if.source rsp_o
);
  import bcdtod_pkg::*;

  logic [HourW-1:0] hours_q, hours_d;
  logic [MinW-1:0]  minutes_q, minutes_d;
  logic [SecW-1:0]  seconds_q, seconds_d;
  logic [HourBcdW-1:0] hour_bcd_q;
  logic [MinBcdW-1:0]  minute_bcd_q;
  logic [SecBcdW-1:0]  second_bcd_q;
  logic [7:0]       hour_bcd_full, minute_bcd_full, second_bcd_full;
  logic             rsp_valid_q;
  logic             take;
  ram_req_t         ram_req;

  // Handshake: accept whenever the result register is free or being emptied.
  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign take        = req_i.valid && req_i.ready;

  // Next time for the current request.
  always_comb begin
    hours_d   = hours_q;
    minutes_d = minutes_q;
    seconds_d = seconds_q;
    case (op_e'(req_i.operation))
      OpTick: begin
        if (seconds_q >= SecMax) begin
          seconds_d = '0;
          if (minutes_q >= MinMax) begin
            minutes_d = '0;
            hours_d   = (hours_q >= HourMax) ? '0 : hours_q + 1'b1;
          end else begin
            minutes_d = minutes_q + 1'b1;
          end
        end else begin
          seconds_d = seconds_q + 1'b1;
        end
      end
      OpSetTime: begin
        hours_d   = (req_i.set_hour > HourMax) ? HourMax : req_i.set_hour;
        minutes_d = (req_i.set_minute > MinMax) ? MinMax : req_i.set_minute;
        seconds_d = (req_i.set_second > SecMax) ? SecMax : req_i.set_second;
      end
      default: begin
        // Reads, memory writes and unused codes leave the time alone.
      end
    endcase
  end

  // Time registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hours_q   <= '0;
      minutes_q <= '0;
      seconds_q <= '0;
    end else if (take) begin
      hours_q   <= hours_d;
      minutes_q <= minutes_d;
      seconds_q <= seconds_d;
    end
  end

  // BCD conversion of the time after this request.
  assign hour_bcd_full   = to_bcd({1'b0, hours_d});
  assign minute_bcd_full = to_bcd(minutes_d);
  assign second_bcd_full = to_bcd(seconds_d);

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q  <= 1'b0;
      hour_bcd_q   <= '0;
      minute_bcd_q <= '0;
      second_bcd_q <= '0;
    end else begin
      if (take) begin
        rsp_valid_q  <= 1'b1;
        hour_bcd_q   <= hour_bcd_full[HourBcdW-1:0];
        minute_bcd_q <= minute_bcd_full[MinBcdW-1:0];
        second_bcd_q <= second_bcd_full[SecBcdW-1:0];
      end else if (rsp_o.ready) begin
        rsp_valid_q  <= 1'b0;
      end
    end
  end

  // Battery RAM access.
  assign ram_req.take  = take;
  assign ram_req.rd    = (req_i.operation == OpReadMem);
  assign ram_req.wr    = take && (req_i.operation == OpWriteMem);
  assign ram_req.addr  = req_i.mem_address;
  assign ram_req.wdata = req_i.write_data;

  bcdtod_ram u_ram (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (ram_req),
    .rdata_o (rsp_o.read_data)
  );

  assign rsp_o.valid      = rsp_valid_q;
  assign rsp_o.hour_bcd   = hour_bcd_q;
  assign rsp_o.minute_bcd = minute_bcd_q;
  assign rsp_o.second_bcd = second_bcd_q;

endmodule

// ===== src/bcdtod_checker.sv =====
// Port-level checker for the BCD time-of-day clock, bound to the top level.
// Depends on bcdtod_pkg and bcd_time_of_day_clock_with_ram_core_macros.svh.
`include "bcd_time_of_day_clock_with_ram_core_macros.svh"

module bcdtod_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            req_valid_i,
  input logic                            req_ready_i,
  input logic [bcdtod_pkg::OpW-1:0]      operation_i,
  input logic                            rsp_valid_i,
  input logic                            rsp_ready_i,
  input logic [bcdtod_pkg::HourBcdW-1:0] hour_bcd_i,
  input logic [bcdtod_pkg::MinBcdW-1:0]  minute_bcd_i,
  input logic [bcdtod_pkg::SecBcdW-1:0]  second_bcd_i,
  input logic [bcdtod_pkg::DataW-1:0]    read_data_i
);
  import bcdtod_pkg::*;

  logic                                req_take;
  logic                                other_take;
  logic                                time_read;
  logic                                take_q;
  logic [HourBcdW+MinBcdW+SecBcdW-1:0] bcd_time;

  assign req_take   = req_valid_i && req_ready_i;
  assign other_take = req_take && (operation_i != OpReadMem);
  assign time_read  = req_take && (operation_i == OpReadTime);
  assign bcd_time   = {hour_bcd_i, minute_bcd_i, second_bcd_i};

  // Remembers whether a request was accepted at the previous edge.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      take_q <= 1'b0;
    end else begin
      take_q <= req_take;
    end
  end

  // A pending result stays offered until it is taken.
  `BCDTOD_ASSERT(a_rsp_hold, rsp_valid_i && !rsp_ready_i |=> rsp_valid_i, "result dropped")

  // Every accepted request yields a result in the next cycle.
  `BCDTOD_ASSERT(a_rsp_follows, req_take |=> rsp_valid_i, "no result after request")

  // Only a memory read can return a nonzero byte.
  `BCDTOD_ASSERT(a_rdata_zero, other_take |=> (read_data_i == '0), "read data not zero")

  // A time read right after another request reports the same time.
  `BCDTOD_ASSERT(a_read_time_stable, time_read && take_q |=> $stable(bcd_time), "time moved")

  // Right after reset is seen low, no result is offered without a prior accepted request.
  `BCDTOD_ASSERT_ALWAYS(a_no_spurious, !rst_ni |=> !rsp_valid_i || take_q, "spurious result")

endmodule

bind bcd_time_of_day_clock_with_ram_core bcdtod_checker u_bcdtod_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req_i.valid),
  .req_ready_i  (req_i.ready),
  .operation_i  (req_i.operation),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .hour_bcd_i   (rsp_o.hour_bcd),
  .minute_bcd_i (rsp_o.minute_bcd),
  .second_bcd_i (rsp_o.second_bcd),
  .read_data_i  (rsp_o.read_data)
);
